FILE: rtl/core/tmcg_pkg.sv
// ----------------------------------------------------------------------------
// tmcg_pkg
// shared types and constants of the text mode character generator
// ----------------------------------------------------------------------------
package tmcg_pkg;

	// default geometry
	localparam int DEF_TEXT_COLUMNS = 48;
	localparam int DEF_TEXT_ROWS    = 32;
	localparam int DEF_ROW_STRIDE   = 64;
	localparam int DEF_GLYPH_WIDTH  = 6;
	localparam int DEF_GLYPH_HEIGHT = 8;

	// memories: 2048 bytes each
	localparam int MEM_AW = 11;
	localparam int MEM_DW = 8;
	localparam int MEM_DEPTH = 1 << MEM_AW;

	// counter widths, sized for the largest legal geometry
	localparam int COL_W  = 6;
	localparam int BIT_W  = 3;
	localparam int ROW_W  = 5;
	localparam int LINE_W = 3;
	localparam int X_W    = 9;
	localparam int Y_W    = 8;

	// code bit that inverts the glyph
	localparam int INVERT_BIT = 7;

	// stream word layout
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 24;

	typedef enum logic [1:0] {
		REQ_VRAM_WR = 2'd0,
		REQ_CROM_WR = 2'd1,
		REQ_TICK    = 2'd2,
		REQ_NONE    = 2'd3
	} req_type_t;

	// raster position of the pixel about to be emitted
	typedef struct packed {
		logic [X_W-1:0]    x;
		logic [Y_W-1:0]    y;
		logic [COL_W-1:0]  col;
		logic [BIT_W-1:0]  bit_idx;
		logic [ROW_W-1:0]  row;
		logic [LINE_W-1:0] line;
		logic              last;
	} raster_pos_t;

endpackage

FILE: rtl/core/tmcg_raster.sv
// ----------------------------------------------------------------------------
// tmcg_raster
// raster position counters, advanced once per pixel tick
// ----------------------------------------------------------------------------
module tmcg_raster #(
	parameter int TEXT_COLUMNS = tmcg_pkg::DEF_TEXT_COLUMNS,
	parameter int TEXT_ROWS    = tmcg_pkg::DEF_TEXT_ROWS,
	parameter int GLYPH_WIDTH  = tmcg_pkg::DEF_GLYPH_WIDTH,
	parameter int GLYPH_HEIGHT = tmcg_pkg::DEF_GLYPH_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	output tmcg_pkg::raster_pos_t pos
);

	logic [tmcg_pkg::X_W-1:0]    x_q;
	logic [tmcg_pkg::Y_W-1:0]    y_q;
	logic [tmcg_pkg::COL_W-1:0]  col_q;
	logic [tmcg_pkg::BIT_W-1:0]  bit_q;
	logic [tmcg_pkg::ROW_W-1:0]  row_q;
	logic [tmcg_pkg::LINE_W-1:0] line_q;

	logic bit_end, col_end, line_end, row_end;

	assign bit_end  = bit_q  == tmcg_pkg::BIT_W'(GLYPH_WIDTH - 1);
	assign col_end  = col_q  == tmcg_pkg::COL_W'(TEXT_COLUMNS - 1);
	assign line_end = line_q == tmcg_pkg::LINE_W'(GLYPH_HEIGHT - 1);
	assign row_end  = row_q  == tmcg_pkg::ROW_W'(TEXT_ROWS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			col_q  <= '0;
			bit_q  <= '0;
			row_q  <= '0;
			line_q <= '0;
		end else if (step) begin
			if (bit_end) begin
				bit_q <= '0;
				if (col_end) begin
					// end of scan line
					col_q <= '0;
					x_q   <= '0;
					if (line_end) begin
						line_q <= '0;
						if (row_end) begin
							row_q <= '0;
							y_q   <= '0;
						end else begin
							row_q <= row_q + 1'b1;
							y_q   <= y_q + 1'b1;
						end
					end else begin
						line_q <= line_q + 1'b1;
						y_q    <= y_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
					x_q   <= x_q + 1'b1;
				end
			end else begin
				bit_q <= bit_q + 1'b1;
				x_q   <= x_q + 1'b1;
			end
		end
	end

	assign pos.x       = x_q;
	assign pos.y       = y_q;
	assign pos.col     = col_q;
	assign pos.bit_idx = bit_q;
	assign pos.row     = row_q;
	assign pos.line    = line_q;
	assign pos.last    = bit_end && col_end && line_end && row_end;

endmodule

FILE: rtl/core/tmcg_vram.sv
// ----------------------------------------------------------------------------
// tmcg_vram
// video ram of character codes, cleared by a sweep after reset
// ----------------------------------------------------------------------------
module tmcg_vram (
	input  logic                        clk,
	input  logic                        arst_n,
	output logic                        ready,
	input  logic                        rd_en,
	input  logic [tmcg_pkg::MEM_AW-1:0] rd_addr,
	output logic [tmcg_pkg::MEM_DW-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [tmcg_pkg::MEM_AW-1:0] wr_addr,
	input  logic [tmcg_pkg::MEM_DW-1:0] wr_data
);

	logic [tmcg_pkg::MEM_DW-1:0] mem [tmcg_pkg::MEM_DEPTH];

	logic [tmcg_pkg::MEM_AW-1:0] clr_addr_q;
	logic                        clr_done_q;

	logic                        we;
	logic [tmcg_pkg::MEM_AW-1:0] waddr;
	logic [tmcg_pkg::MEM_DW-1:0] wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	always_comb begin
		if (!clr_done_q) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			we    = wr_en;
			waddr = wr_addr;
			wdata = wr_data;
		end
	end

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign ready = clr_done_q;

endmodule

FILE: rtl/core/tmcg_crom.sv
// ----------------------------------------------------------------------------
// tmcg_crom
// character rom of glyph rows, loaded through the write port
// ----------------------------------------------------------------------------
module tmcg_crom (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [tmcg_pkg::MEM_AW-1:0] rd_addr,
	output logic [tmcg_pkg::MEM_DW-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [tmcg_pkg::MEM_AW-1:0] wr_addr,
	input  logic [tmcg_pkg::MEM_DW-1:0] wr_data
);

	logic [tmcg_pkg::MEM_DW-1:0] mem [tmcg_pkg::MEM_DEPTH];

	// read-first: a write in the same cycle lands after the read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/text_mode_character_generator.sv
// ----------------------------------------------------------------------------
// text_mode_character_generator
// character cell raster generator: video ram codes, glyph rom, pixel stream
// ----------------------------------------------------------------------------
//
// channel  dir  tdata fields (lsb first)                tuser          extra
// -------  ---  --------------------------------------  -------------  ---------------
// s_axis   in   wr_addr[10:0] wr_data[18:11]            req_type[1:0]  -
// m_axis   out  pixel[0] pixel_x[9:1] pixel_y[17:10]    -              tlast = frame_end
//
// one word accepted per cycle, writes and ticks alike, while the output is not
// stalled and the ram sweep is done; a tick's pixel word passes the video ram
// read, the glyph rom read and the output reg
// after reset the video ram is swept to zero, s_axis_tready low
// a stalled output freezes the whole pipeline and both memory read ports
// memory writes commit at acceptance; both memories return old data on a
// same-cycle read, which keeps item order without forwarding
//
module text_mode_character_generator #(
	parameter int TEXT_COLUMNS = tmcg_pkg::DEF_TEXT_COLUMNS,
	parameter int TEXT_ROWS    = tmcg_pkg::DEF_TEXT_ROWS,
	parameter int ROW_STRIDE   = tmcg_pkg::DEF_ROW_STRIDE,
	parameter int GLYPH_WIDTH  = tmcg_pkg::DEF_GLYPH_WIDTH,
	parameter int GLYPH_HEIGHT = tmcg_pkg::DEF_GLYPH_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// wr_addr, wr_data, zero pad
	input  logic [tmcg_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// req_type
	input  logic [tmcg_pkg::S_TUSER_W-1:0] s_axis_tuser,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// pixel, pixel_x, pixel_y, zero pad
	output logic [tmcg_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic                           m_axis_tlast
);

	localparam int AW = tmcg_pkg::MEM_AW;
	localparam int DW = tmcg_pkg::MEM_DW;

	// input word unpack
	tmcg_pkg::req_type_t req_type;
	logic [AW-1:0]       wr_addr;
	logic [DW-1:0]       wr_data;

	assign req_type = tmcg_pkg::req_type_t'(s_axis_tuser);
	assign wr_addr  = s_axis_tdata[10:0];
	assign wr_data  = s_axis_tdata[18:11];

	// pipeline moves when the output register is free or being drained
	logic adv;
	logic vram_ready;
	logic accept;
	logic tick;

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv && vram_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign tick          = accept && (req_type == tmcg_pkg::REQ_TICK);

	// raster counters
	tmcg_pkg::raster_pos_t pos;

	tmcg_raster #(
		.TEXT_COLUMNS (TEXT_COLUMNS),
		.TEXT_ROWS    (TEXT_ROWS),
		.GLYPH_WIDTH  (GLYPH_WIDTH),
		.GLYPH_HEIGHT (GLYPH_HEIGHT)
	) u_raster (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (tick),
		.pos    (pos)
	);

	// video ram address: row * stride + column, wrapped to the memory size
	logic [AW+tmcg_pkg::COL_W-1:0] vram_addr_full;
	logic [AW-1:0]                 vram_rd_addr;
	logic [DW-1:0]                 code_s1;

	assign vram_addr_full = (AW + tmcg_pkg::COL_W)'(pos.row)
		* (AW + tmcg_pkg::COL_W)'(ROW_STRIDE)
		+ (AW + tmcg_pkg::COL_W)'(pos.col);
	assign vram_rd_addr = vram_addr_full[AW-1:0];

	tmcg_vram u_vram (
		.clk     (clk),
		.arst_n  (arst_n),
		.ready   (vram_ready),
		.rd_en   (adv),
		.rd_addr (vram_rd_addr),
		.rd_data (code_s1),
		.wr_en   (accept && (req_type == tmcg_pkg::REQ_VRAM_WR)),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// stage 1: character code from video ram
	logic                              tick_s1;
	logic [tmcg_pkg::X_W-1:0]          x_s1;
	logic [tmcg_pkg::Y_W-1:0]          y_s1;
	logic [tmcg_pkg::BIT_W-1:0]        bit_s1;
	logic [tmcg_pkg::LINE_W-1:0]       line_s1;
	logic                              last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_s1 <= 1'b0;
		end else if (adv) begin
			tick_s1 <= tick;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= pos.x;
			y_s1    <= pos.y;
			bit_s1  <= pos.bit_idx;
			line_s1 <= pos.line;
			last_s1 <= pos.last;
		end
	end

	// glyph address: code * 8 + line, always within 2048 bytes
	logic [AW-1:0] crom_rd_addr;
	logic [DW-1:0] glyph_s2;

	assign crom_rd_addr = {code_s1, line_s1};

	tmcg_crom u_crom (
		.clk     (clk),
		.rd_en   (adv),
		.rd_addr (crom_rd_addr),
		.rd_data (glyph_s2),
		.wr_en   (accept && (req_type == tmcg_pkg::REQ_CROM_WR)),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// stage 2: glyph row from character rom
	logic                        tick_s2;
	logic [tmcg_pkg::X_W-1:0]    x_s2;
	logic [tmcg_pkg::Y_W-1:0]    y_s2;
	logic [tmcg_pkg::BIT_W-1:0]  bit_s2;
	logic                        inv_s2;
	logic                        last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_s2 <= 1'b0;
		end else if (adv) begin
			tick_s2 <= tick_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			bit_s2  <= bit_s1;
			inv_s2  <= code_s1[tmcg_pkg::INVERT_BIT];
			last_s2 <= last_s1;
		end
	end

	// leftmost pixel is glyph bit GLYPH_WIDTH-1; inverse video flips it
	logic [tmcg_pkg::BIT_W-1:0] sel_idx;
	logic                       pixel_s2;

	assign sel_idx  = tmcg_pkg::BIT_W'(GLYPH_WIDTH - 1) - bit_s2;
	assign pixel_s2 = glyph_s2[sel_idx] ^ inv_s2;

	// output register
	logic                     out_valid_q;
	logic                     pixel_q;
	logic [tmcg_pkg::X_W-1:0] x_q;
	logic [tmcg_pkg::Y_W-1:0] y_q;
	logic                     last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tick_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_q <= pixel_s2;
			x_q     <= x_s2;
			y_q     <= y_s2;
			last_q  <= last_s2;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, y_q, x_q, pixel_q};
	assign m_axis_tlast  = last_q;

	// no word taken while the video ram sweep runs
	assert property (@(posedge clk) disable iff (!arst_n)
		!vram_ready |-> !s_axis_tready)
	else $error("input accepted during video ram clear");

	// an accepted tick reaches stage 1 on the next edge
	assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> tick_s1)
	else $error("tick lost entering the pipeline");

	// frame end only on the bottom-right pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
		(y_q == tmcg_pkg::Y_W'(TEXT_ROWS * GLYPH_HEIGHT - 1)) &&
		(x_q == tmcg_pkg::X_W'(TEXT_COLUMNS * GLYPH_WIDTH - 1)))
	else $error("frame end away from the last pixel");

endmodule

FILE: tb/sv/tb_text_mode_character_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_mode_character_generator
// self-checking bench for the text mode character generator: video ram and
// glyph rom writes mixed with pixel ticks, every pixel word compared against a
// behavioral raster model or a directed value, random idling on both streams
// ----------------------------------------------------------------------------
module tb_text_mode_character_generator;

	localparam int GW          = tmcg_pkg::DEF_GLYPH_WIDTH;
	localparam int GH          = tmcg_pkg::DEF_GLYPH_HEIGHT;
	localparam int STRIDE      = tmcg_pkg::DEF_ROW_STRIDE;
	localparam int FRAME_W     = tmcg_pkg::DEF_TEXT_COLUMNS * tmcg_pkg::DEF_GLYPH_WIDTH;
	localparam int FRAME_H     = tmcg_pkg::DEF_TEXT_ROWS * tmcg_pkg::DEF_GLYPH_HEIGHT;
	localparam int DEPTH       = tmcg_pkg::MEM_DEPTH;
	localparam int GLYPH_BYTES = 8;
	localparam int IDLE_PCT    = 36;
	localparam int RANDOM_WORDS = 1700;
	localparam int DRAIN_CYCLES = 16;
	// covers the ram sweep after reset plus all the words, with stalls on
	// both sides included
	localparam longint CYCLE_LIMIT = 200_000;

	typedef logic [tmcg_pkg::MEM_AW-1:0] addr_t;
	typedef logic [tmcg_pkg::MEM_DW-1:0] byte_t;
	typedef logic [tmcg_pkg::X_W-1:0]    xpos_t;
	typedef logic [tmcg_pkg::Y_W-1:0]    ypos_t;

	typedef struct packed {
		logic  lit;
		xpos_t x;
		ypos_t y;
		logic  frame_end;
	} pixel_t;

	typedef struct packed {
		tmcg_pkg::req_type_t req;
		addr_t               addr;
		byte_t               data;
		logic                typed;
		pixel_t              want;
	} stim_row_t;

	logic                           clk;
	logic                           arst_n;
	logic [tmcg_pkg::S_TDATA_W-1:0] s_axis_tdata;
	logic [tmcg_pkg::S_TUSER_W-1:0] s_axis_tuser;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [tmcg_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic                           m_axis_tlast;

	// raster model state
	byte_t vram [DEPTH];
	byte_t crom [DEPTH];
	bit    crom_known [DEPTH];
	xpos_t raster_x;
	ypos_t raster_y;

	pixel_t    pixel_q [$];
	stim_row_t script [$];
	int        errors;
	longint    cycles;
	bit        no_idle;

	text_mode_character_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(string what);
		errors++;
		$display("cycle %0d: %s", cycles, what);
	endtask

	function automatic byte_t char_code(xpos_t x, ypos_t y);
		int idx;
		idx = (int'(y) / GH * STRIDE + int'(x) / GW) % DEPTH;
		return vram[idx];
	endfunction

	function automatic addr_t glyph_addr(xpos_t x, ypos_t y);
		int a;
		a = (int'(char_code(x, y)) * GLYPH_BYTES + int'(y) % GH) % DEPTH;
		return a[tmcg_pkg::MEM_AW-1:0];
	endfunction

	// drive one word, wait for it to go in, then run the model on it
	task automatic put_word(tmcg_pkg::req_type_t req, addr_t addr,
			byte_t data, logic typed, pixel_t want);
		pixel_t px;
		byte_t  code;
		byte_t  glyph;
		s_axis_tdata  <= {{(tmcg_pkg::S_TDATA_W - 19){1'b0}}, data, addr};
		s_axis_tuser  <= req;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		case (req)
			tmcg_pkg::REQ_VRAM_WR: vram[addr] = data;
			tmcg_pkg::REQ_CROM_WR: begin
				crom[addr] = data;
				crom_known[addr] = 1'b1;
			end
			tmcg_pkg::REQ_TICK: begin
				code  = char_code(raster_x, raster_y);
				glyph = crom[glyph_addr(raster_x, raster_y)];
				if (code[tmcg_pkg::INVERT_BIT])
					glyph = ~glyph;
				px.lit       = glyph[GW - 1 - int'(raster_x) % GW];
				px.x         = raster_x;
				px.y         = raster_y;
				px.frame_end = (raster_x == FRAME_W - 1) && (raster_y == FRAME_H - 1);
				pixel_q.push_back(typed ? want : px);
				// raster advance with line and frame wrap
				if (raster_x == FRAME_W - 1) begin
					raster_x = '0;
					if (raster_y == FRAME_H - 1)
						raster_y = '0;
					else
						raster_y = raster_y + 1'b1;
				end else begin
					raster_x = raster_x + 1'b1;
				end
			end
			default: ;
		endcase
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// a tick never reads a glyph byte that was not written first
	task automatic send(tmcg_pkg::req_type_t req, addr_t addr, byte_t data);
		addr_t ga;
		if (req == tmcg_pkg::REQ_TICK) begin
			ga = glyph_addr(raster_x, raster_y);
			if (!crom_known[ga])
				put_word(tmcg_pkg::REQ_CROM_WR, ga, byte_t'($urandom_range(255)),
					1'b0, '0);
		end
		put_word(req, addr, data, 1'b0, '0);
	endtask

	task automatic random_word(int tick_pct);
		int    pick;
		addr_t ra;
		byte_t rd;
		pick = $urandom_range(99);
		ra   = addr_t'($urandom_range(DEPTH - 1));
		rd   = byte_t'($urandom_range(255));
		if (pick < tick_pct) begin
			send(tmcg_pkg::REQ_TICK, ra, rd);
		end else begin
			pick = $urandom_range(99);
			if (pick < 45)
				send(tmcg_pkg::REQ_VRAM_WR, ra, rd);
			else if (pick < 90)
				send(tmcg_pkg::REQ_CROM_WR, ra, rd);
			else
				send(tmcg_pkg::REQ_NONE, ra, rd);
		end
	endtask

	task automatic add_row(tmcg_pkg::req_type_t req, addr_t addr, byte_t data,
			logic typed, logic lit, xpos_t x);
		stim_row_t row;
		row.req            = req;
		row.addr           = addr;
		row.data           = data;
		row.typed          = typed;
		row.want.lit       = lit;
		row.want.x         = x;
		row.want.y         = '0;
		row.want.frame_end = 1'b0;
		script.push_back(row);
	endtask

	// output side: random stalls, every pixel word against the oldest prediction
	always @(posedge clk) begin : pixel_check
		pixel_t got;
		pixel_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.lit       = m_axis_tdata[0];
				got.x         = m_axis_tdata[9:1];
				got.y         = m_axis_tdata[17:10];
				got.frame_end = m_axis_tlast;
				if (pixel_q.size() == 0) begin
					report_mismatch($sformatf("pixel word (%0d,%0d) with none pending",
						got.x, got.y));
				end else begin
					want = pixel_q.pop_front();
					if (got.lit !== want.lit)
						report_mismatch($sformatf("pixel (%0d,%0d) lit %b, want %b",
							want.x, want.y, got.lit, want.lit));
					if (got.x !== want.x)
						report_mismatch($sformatf("pixel_x %0d, want %0d", got.x, want.x));
					if (got.y !== want.y)
						report_mismatch($sformatf("pixel_y %0d, want %0d", got.y, want.y));
					if (got.frame_end !== want.frame_end)
						report_mismatch($sformatf("frame end %b at (%0d,%0d), want %b",
							got.frame_end, want.x, want.y, want.frame_end));
				end
			end
			m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		arst_n        <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		s_axis_tvalid <= 1'b0;
		m_axis_tready <= 1'b0;
		foreach (vram[i]) begin
			vram[i]       = '0;
			crom[i]       = '0;
			crom_known[i] = 1'b0;
		end
		raster_x = '0;
		raster_y = '0;
		errors   = 0;
		cycles   = 0;
		no_idle  = 1'b0;

		// directed words: glyph bit order, ignored request, inverted codes,
		// extreme addresses and data
		add_row(tmcg_pkg::REQ_CROM_WR, 11'd0,    8'h20, 1'b0, 1'b0, 9'd0);
		add_row(tmcg_pkg::REQ_TICK,    11'd0,    8'h00, 1'b1, 1'b1, 9'd0);
		add_row(tmcg_pkg::REQ_TICK,    11'd0,    8'h00, 1'b1, 1'b0, 9'd1);
		add_row(tmcg_pkg::REQ_NONE,    11'd2047, 8'hff, 1'b0, 1'b0, 9'd0);
		add_row(tmcg_pkg::REQ_TICK,    11'd0,    8'h00, 1'b1, 1'b0, 9'd2);
		add_row(tmcg_pkg::REQ_CROM_WR, 11'd0,    8'h1f, 1'b0, 1'b0, 9'd0);
		add_row(tmcg_pkg::REQ_TICK,    11'd0,    8'h00, 1'b1, 1'b1, 9'd3);
		add_row(tmcg_pkg::REQ_VRAM_WR, 11'd0,    8'h80, 1'b0, 1'b0, 9'd0);
		add_row(tmcg_pkg::REQ_CROM_WR, 11'd1024, 8'hff, 1'b0, 1'b0, 9'd0);
		add_row(tmcg_pkg::REQ_TICK,    11'd0,    8'h00, 1'b1, 1'b0, 9'd4);
		add_row(tmcg_pkg::REQ_CROM_WR, 11'd1024, 8'h00, 1'b0, 1'b0, 9'd0);
		add_row(tmcg_pkg::REQ_TICK,    11'd0,    8'h00, 1'b1, 1'b1, 9'd5);
		add_row(tmcg_pkg::REQ_VRAM_WR, 11'd2047, 8'hff, 1'b0, 1'b0, 9'd0);
		add_row(tmcg_pkg::REQ_CROM_WR, 11'd2047, 8'hff, 1'b0, 1'b0, 9'd0);
		add_row(tmcg_pkg::REQ_VRAM_WR, 11'd1,    8'hff, 1'b0, 1'b0, 9'd0);
		add_row(tmcg_pkg::REQ_CROM_WR, 11'd2040, 8'h00, 1'b0, 1'b0, 9'd0);
		add_row(tmcg_pkg::REQ_TICK,    11'd0,    8'h00, 1'b1, 1'b1, 9'd6);
		add_row(tmcg_pkg::REQ_CROM_WR, 11'd2040, 8'hc0, 1'b0, 1'b0, 9'd0);
		add_row(tmcg_pkg::REQ_TICK,    11'd2047, 8'hff, 1'b0, 1'b0, 9'd0);
		add_row(tmcg_pkg::REQ_VRAM_WR, 11'd1,    8'h00, 1'b0, 1'b0, 9'd0);
		add_row(tmcg_pkg::REQ_TICK,    11'd0,    8'h00, 1'b0, 1'b0, 9'd0);
		add_row(tmcg_pkg::REQ_NONE,    11'd0,    8'h00, 1'b0, 1'b0, 9'd0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			put_word(script[i].req, script[i].addr, script[i].data, script[i].typed,
				script[i].want);

		// random mix, with a stretch where neither side idles
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			no_idle = (i >= 700) && (i < 1000);
			random_word(68);
		end
		no_idle = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: text_mode_character_generator.f
rtl/core/tmcg_pkg.sv
rtl/core/tmcg_raster.sv
rtl/core/tmcg_vram.sv
rtl/core/tmcg_crom.sv
rtl/core/text_mode_character_generator.sv
tb/sv/tb_text_mode_character_generator.sv
